### hdl/pslat_pkg.sv
package pslat_pkg;

  localparam int NumSlots = 13;
  localparam int SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int CntW = SlotW + 1;

  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_REPORT   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [31:0] INTERVAL_RESET = 32'd3000;
  localparam logic [6:0]  PCT_SCALE = 7'd100;
  localparam logic [9:0]  MS_SCALE = 10'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  probe;
    logic [31:0] duration_us;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] window_ms;
    logic [3:0]  slot_id;
    logic [31:0] event_count;
    logic [31:0] average_us;
    logic [31:0] peak_us;
    logic [31:0] load_percent;
    logic        last;
  } rsp_t;

endpackage

### hdl/pslat_if.sv
interface pslat_req_if;
  import pslat_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pslat_rsp_if;
  import pslat_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/pslat_div.sv
// Restoring divider, 64-bit dividend and divisor, one quotient bit per cycle.
// done rises when the quotient is ready and stays high until the next start.
module pslat_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem, quo[63]};
  assign diff = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= 7'd64;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/per_slot_latency_statistics_unit.sv
// A sample request does a read-modify-write of its slot, and a clear zeroes the slots one
// at a time after the accepting cycle. A report whose window reaches the interval walks the
// slots one at a time; every slot with a nonzero count goes through the one shared 64-bit
// serial divider twice (average, then load), but the load division is skipped when the
// window is zero. A report's steps are the header, a scan of each slot, the final item and
// a closing clear of every slot.
// The block takes no request while it works or while an item waits in its output register.
module per_slot_latency_statistics_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata,
  pslat_req_if.sink req,
  pslat_rsp_if.source rsp
);
  import pslat_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SAMP  = 8'b00000010,
    S_CLR   = 8'b00000100,
    S_HDR   = 8'b00001000,
    S_SCAN  = 8'b00010000,
    S_AVG   = 8'b00100000,
    S_LOAD  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t state;
  logic [31:0] interval;
  logic [31:0] last_report;
  logic [31:0] counts [NumSlots];
  logic [63:0] totals [NumSlots];
  logic [31:0] peaks [NumSlots];
  req_t cur;
  logic [SlotW-1:0] idx;
  logic [31:0] window;
  logic [63:0] denom;
  logic [31:0] avg;
  logic        has_prev;
  logic        out_valid;
  rsp_t out_data;
  rsp_t pend;
  logic        pend_valid;
  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic [31:0] cur_window;
  logic [SlotW-1:0] probe_idx;
  logic        at_end;

  assign cur_window = req.data.now_ms - last_report;
  assign probe_idx = cur.probe[SlotW-1:0];
  assign at_end = ({1'b0, idx} == CntW'(NumSlots - 1));
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  pslat_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_a = totals[idx];
    div_b = {32'd0, counts[idx]};
    if (state == S_SCAN && counts[idx] != 32'd0 && !pend_valid) begin
      div_start = 1'b1;
    end else if (state == S_AVG && div_done) begin
      div_start = (denom != 64'd0);
      div_a = totals[idx] * 64'(PCT_SCALE);
      div_b = denom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      interval <= INTERVAL_RESET;
      last_report <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
      idx <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        counts[i] <= '0;
        totals[i] <= '0;
        peaks[i] <= '0;
      end
    end else begin
      if (cfg_we) interval <= cfg_wdata;
      // A held item moves to the output as soon as it is free.
      if (pend_valid && (!out_valid || rsp.ready)) begin
        out_data <= pend;
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            idx <= '0;
            case (req.data.op)
              OP_SAMPLE: if ({1'b0, req.data.probe} < 5'(NumSlots)) state <= S_SAMP;
              OP_CLEAR: state <= S_CLR;
              OP_REPORT: begin
                if (cur_window >= interval) begin
                  last_report <= req.data.now_ms;
                  window <= cur_window;
                  denom <= 64'(cur_window) * 64'(MS_SCALE);
                  state <= S_HDR;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SAMP: begin
          counts[probe_idx] <= counts[probe_idx] + 32'd1;
          totals[probe_idx] <= totals[probe_idx] + 64'(cur.duration_us);
          if (cur.duration_us > peaks[probe_idx]) peaks[probe_idx] <= cur.duration_us;
          state <= S_IDLE;
        end
        S_CLR: begin
          counts[idx] <= '0;
          totals[idx] <= '0;
          peaks[idx] <= '0;
          idx <= idx + 1'b1;
          if (at_end) state <= S_IDLE;
        end
        S_HDR: begin
          // The header is held back until the next item tells whether it is the last.
          pend <= '{kind: 1'b0, window_ms: window, slot_id: 4'd0, event_count: 32'd0,
                    average_us: 32'd0, peak_us: 32'd0, load_percent: 32'd0, last: 1'b0};
          has_prev <= 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (counts[idx] != 32'd0) begin
            if (!pend_valid) state <= S_AVG;
          end else if (at_end) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
          // Release the previous item once this slot turns out active.
          if (counts[idx] != 32'd0 && has_prev && !pend_valid) begin
            pend_valid <= 1'b1;
            has_prev <= 1'b0;
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg <= div_q[31:0];
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (denom == 64'd0 || div_done) begin
            if (!pend_valid) begin
              pend <= '{kind: 1'b1, window_ms: window, slot_id: 4'(idx),
                        event_count: counts[idx], average_us: avg, peak_us: peaks[idx],
                        load_percent: (denom == 64'd0) ? 32'hFFFF_FFFF : div_q[31:0],
                        last: 1'b0};
              has_prev <= 1'b1;
              if (at_end) state <= S_EMIT;
              else begin
                idx <= idx + 1'b1;
                state <= S_SCAN;
              end
            end
          end
        end
        S_EMIT: begin
          if (!pend_valid) begin
            pend.last <= 1'b1;
            pend_valid <= 1'b1;
            has_prev <= 1'b0;
            idx <= '0;
            state <= S_CLR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !req.ready;
  endproperty
  a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !pend_valid) |=> (pend_valid && pend.last))
    else $error("last item not flagged");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == S_SCAN || state == S_AVG)) else $error("stray divide");

endmodule

### tb/sv/pslat_checker.sv
`timescale 1ns / 100ps

module pslat_checker
  import pslat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] interval_ms;
  logic [31:0] counts [NumSlots];
  logic [63:0] totals [NumSlots];
  logic [31:0] peaks [NumSlots];
  logic [31:0] last_report;
  rsp_t        expected_stats [$];

  assign pending = expected_stats.size();

  task automatic clear_table();
    for (int i = 0; i < NumSlots; i++) begin
      counts[i] = '0;
      totals[i] = '0;
      peaks[i] = '0;
    end
  endtask

  // Applies one request to the shadow table and queues the items it produces.
  task automatic predict_request(input req_t r);
    logic [31:0] window;
    logic [63:0] denom;
    logic [63:0] load;
    logic [63:0] scaled;
    rsp_t        item;
    if (r.op == OP_SAMPLE) begin
      if (r.probe < NumSlots) begin
        counts[r.probe] = counts[r.probe] + 32'd1;
        totals[r.probe] = totals[r.probe] + {32'd0, r.duration_us};
        if (r.duration_us > peaks[r.probe]) peaks[r.probe] = r.duration_us;
      end
    end else if (r.op == OP_CLEAR) begin
      clear_table();
    end else if (r.op == OP_REPORT) begin
      window = r.now_ms - last_report;
      if (window >= interval_ms) begin
        last_report = r.now_ms;
        item = '0;
        item.window_ms = window;
        expected_stats.push_back(item);
        denom = {32'd0, window} * 64'd1000;
        for (int i = 0; i < NumSlots; i++) begin
          if (counts[i] != 0) begin
            scaled = totals[i] * 64'd100;
            load = (denom != 0) ? scaled / denom : 64'hFFFF_FFFF;
            item = '0;
            item.kind = 1'b1;
            item.window_ms = window;
            item.slot_id = 4'(i);
            item.event_count = counts[i];
            item.average_us = 32'(totals[i] / {32'd0, counts[i]});
            item.peak_us = peaks[i];
            item.load_percent = load[31:0];
            expected_stats.push_back(item);
          end
        end
        expected_stats[expected_stats.size() - 1].last = 1'b1;
        clear_table();
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      interval_ms = INTERVAL_RESET;
      last_report = '0;
      clear_table();
      expected_stats.delete();
      fail_count <= 0;
    end else begin
      // A request sees the interval from before a write at the same edge.
      if (req_valid && req_ready) predict_request(req_data);
      if (cfg_we) interval_ms = cfg_wdata;
      if (rsp_valid && rsp_ready) begin
        if (expected_stats.size() == 0) begin
          if (fail_count < 10) $display("%0t: unexpected report item %p", $realtime, rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_stats.pop_front();
          if (rsp_data !== want) begin
            if (fail_count < 10)
              $display("%0t: report item mismatch\n  expected %p\n  actual   %p",
                       $realtime, want, rsp_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pslat_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  logic        stall_on = 1'b1;
  logic [31:0] clock_ms = '0;
  int          hold_cycles = 0;

  pslat_req_if req ();
  pslat_rsp_if rsp ();

  per_slot_latency_statistics_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  pslat_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  function automatic int gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
  end

  // Result side: random back-pressure with an occasional long stall, switched off during
  // some phases.
  always @(negedge clk) begin
    if (!stall_on) rsp.ready <= 1'b1;
    else if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      hold_cycles = $urandom_range(10, 40);
      rsp.ready <= 1'b0;
    end
    else if ($urandom_range(0, 9) == 0) rsp.ready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 1) == 1);
  end

  task automatic idle_request();
    req.valid <= 1'b0;
    req.data <= '0;
  endtask

  // The request stays driven after acceptance until the next request or an idle gap.
  task automatic send_request(input req_t r);
    int gap;
    gap = stall_on ? gap_cycles() : 0;
    if (gap != 0) begin
      idle_request();
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sample(input logic [3:0] probe, input logic [31:0] dur);
    req_t r;
    r = '0;
    r.op = OP_SAMPLE;
    r.probe = probe;
    r.duration_us = dur;
    r.now_ms = $urandom();
    send_request(r);
  endtask

  task automatic report(input logic [31:0] now);
    req_t r;
    r = '0;
    r.op = OP_REPORT;
    r.probe = 4'($urandom());
    r.duration_us = $urandom();
    r.now_ms = now;
    send_request(r);
  endtask

  task automatic other_op(input logic [1:0] op);
    req_t r;
    r.op = op;
    r.probe = 4'($urandom());
    r.duration_us = $urandom();
    r.now_ms = $urandom();
    send_request(r);
  endtask

  task automatic write_interval(input logic [31:0] value);
    idle_request();
    while (pending != 0) @(negedge clk);
    repeat (2200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_duration();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // A phase of n random requests: mostly samples, also reports, clears and reserved ops.
  task automatic random_phase(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 13) sample(4'($urandom_range(0, 15)), random_duration());
      else if (k < 17) begin
        clock_ms = clock_ms + (($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6000));
        report(clock_ms);
      end else if (k == 17) other_op(OP_CLEAR);
      else if (k == 18) other_op(OP_RESERVED);
      else report($urandom());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: too-early report, empty report, extremes, out-of-range slots.
    report(32'd2999);
    report(32'd3000);
    sample(4'd0, 32'd0);
    sample(4'd0, 32'hFFFF_FFFF);
    sample(4'd12, 32'd7);
    sample(4'd13, 32'd5);
    sample(4'd15, 32'hFFFF_FFFF);
    other_op(OP_RESERVED);
    report(32'd6000);
    sample(4'd3, 32'd10);
    other_op(OP_CLEAR);
    report(32'd9000);
    sample(4'd5, 32'hAAAA_5555);
    report(32'hFFFF_FFFF);
    sample(4'd1, 32'h5555_AAAA);
    report(32'd3100);
    clock_ms = 32'd3100;

    write_interval(32'd0);
    // Zero window gives a saturated load.
    sample(4'd2, 32'd100);
    sample(4'd2, 32'd300);
    report(clock_ms);
    random_phase(60);

    write_interval(32'hFFFF_FFFF);
    sample(4'd4, 32'd9);
    report(clock_ms - 32'd1);
    report(clock_ms + 32'hFFFF_FFFF);
    random_phase(30);

    write_interval(32'd1);
    stall_on = 1'b0;
    random_phase(40);
    stall_on = 1'b1;

    write_interval($urandom_range(1, 5000));
    random_phase(70);

    idle_request();
    while (pending != 0) @(negedge clk);
    repeat (2500) @(negedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
